@@ rtl/dfh_pkg.sv @@
`default_nettype none
package dfh_pkg;

  // fixed field widths
  localparam int KEY_W  = 32;
  localparam int SIZE_W = 31;

  // decimal radix, smallest table, table size after reset
  localparam logic [4:0]        RADIX      = 5'd10;
  localparam logic [SIZE_W-1:0] MIN_TABLE  = 31'd10;
  localparam logic [SIZE_W-1:0] RESET_SIZE = 31'd1024;

  // x / 10 == (x * RECIP) >> RECIP_SHIFT, exact for every 32-bit x
  localparam logic [31:0] RECIP       = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  // control bits that travel with each beat down the pipeline
  typedef struct packed {
    logic valid;
    logic done;   // value already below table size
  } dfh_ctl_t;

endpackage
`default_nettype wire

@@ rtl/dfh_key_if.sv @@
`default_nettype none
interface dfh_key_if import dfh_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface
`default_nettype wire

@@ rtl/dfh_index_if.sv @@
`default_nettype none
interface dfh_index_if import dfh_pkg::*;;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] index;

  modport source (output valid, output index, input ready);
  modport sink   (input valid, input index, output ready);
endinterface
`default_nettype wire

@@ rtl/dfh_cfg_if.sv @@
`default_nettype none
interface dfh_cfg_if import dfh_pkg::*;;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] table_size;

  modport source (output valid, output table_size, input ready);
  modport sink   (input valid, input table_size, output ready);
endinterface
`default_nettype wire

@@ rtl/dfh_split.sv @@
`default_nettype none
// One decimal digit of key magnitude and of table size per stage.
module dfh_split import dfh_pkg::*; #(
  parameter int NDIG = 10,
  parameter int POS  = 0
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire dfh_ctl_t               ctl_i,
  input  wire logic [KEY_W-1:0]       xk_i,
  input  wire logic [SIZE_W-1:0]      xs_i,
  input  wire logic [NDIG-1:0][3:0]   dk_i,
  input  wire logic [NDIG-1:0][3:0]   ds_i,
  output dfh_ctl_t                    ctl_o,
  output logic [KEY_W-1:0]            xk_o,
  output logic [SIZE_W-1:0]           xs_o,
  output logic [NDIG-1:0][3:0]        dk_o,
  output logic [NDIG-1:0][3:0]        ds_o
);

  logic [63:0]            pk, ps;
  logic [KEY_W-1:0]       qk_d;
  logic [SIZE_W-1:0]      qs_d;
  logic [KEY_W-1:0]       remk;
  logic [SIZE_W-1:0]      rems;
  logic [NDIG-1:0][3:0]   dk_d, ds_d;

  dfh_ctl_t               ctl_q;
  logic [KEY_W-1:0]       xk_q;
  logic [SIZE_W-1:0]      xs_q;
  logic [NDIG-1:0][3:0]   dk_q, ds_q;

  // divide by ten through the reciprocal, remainder by shift-add
  assign pk   = {32'd0, xk_i} * {32'd0, RECIP};
  assign ps   = {33'd0, xs_i} * {32'd0, RECIP};
  assign qk_d = {3'd0, pk[63:RECIP_SHIFT]};
  assign qs_d = {2'd0, ps[63:RECIP_SHIFT]};
  assign remk = xk_i - ((qk_d << 3) + (qk_d << 1));
  assign rems = xs_i - ((qs_d << 3) + (qs_d << 1));

  always_comb begin
    dk_d      = dk_i;
    ds_d      = ds_i;
    dk_d[POS] = remk[3:0];
    ds_d[POS] = rems[3:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xk_q <= qk_d;
      xs_q <= qs_d;
      dk_q <= dk_d;
      ds_q <= ds_d;
    end
  end

  assign ctl_o = ctl_q;
  assign xk_o  = xk_q;
  assign xs_o  = xs_q;
  assign dk_o  = dk_q;
  assign ds_o  = ds_q;

endmodule
`default_nettype wire

@@ rtl/dfh_lead.sv @@
`default_nettype none
// Finds top nonzero digit; drops digits above fold width unless done.
module dfh_lead import dfh_pkg::*; #(
  parameter int NDIG   = 10,
  parameter int DIGITS = 10,
  parameter int TW     = 4
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire dfh_ctl_t               ctl_i,
  input  wire logic [NDIG-1:0][3:0]   dv_i,
  input  wire logic [NDIG-1:0][3:0]   ds_i,
  output dfh_ctl_t                    ctl_o,
  output logic [TW-1:0]               t_o,
  output logic [NDIG-1:0][3:0]        dv_o,
  output logic [NDIG-1:0][3:0]        ds_o
);

  logic [TW-1:0]          t_d;
  logic [NDIG-1:0][3:0]   dv_d;

  dfh_ctl_t               ctl_q;
  logic [TW-1:0]          t_q;
  logic [NDIG-1:0][3:0]   dv_q, ds_q;

  // priority pick of the top digit; high digits only matter unfolded
  always_comb begin
    t_d  = '0;
    dv_d = dv_i;
    for (int i = 0; i < NDIG; i++) begin
      if (i < DIGITS && dv_i[i] != 4'd0) t_d = TW'(i);
      if (i >= DIGITS && !ctl_i.done)     dv_d[i] = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q  <= t_d;
      dv_q <= dv_d;
      ds_q <= ds_i;
    end
  end

  assign ctl_o = ctl_q;
  assign t_o   = t_q;
  assign dv_o  = dv_q;
  assign ds_o  = ds_q;

endmodule
`default_nettype wire

@@ rtl/dfh_fold.sv @@
`default_nettype none
// One fold round: pair digits from both ends, sum mod 10, recheck size.
module dfh_fold import dfh_pkg::*; #(
  parameter int NDIG = 10,
  parameter int TW   = 4
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire dfh_ctl_t               ctl_i,
  input  wire logic [TW-1:0]          t_i,
  input  wire logic [NDIG-1:0][3:0]   dv_i,
  input  wire logic [NDIG-1:0][3:0]   ds_i,
  output dfh_ctl_t                    ctl_o,
  output logic [TW-1:0]               t_o,
  output logic [NDIG-1:0][3:0]        dv_o,
  output logic [NDIG-1:0][3:0]        ds_o
);

  // decimal a < b, digit 0 least significant
  function automatic logic dig_lt(input logic [NDIG-1:0][3:0] a,
                                  input logic [NDIG-1:0][3:0] b);
    logic lt;
    lt = 1'b0;
    for (int i = 0; i < NDIG; i++) begin
      lt = (a[i] < b[i]) | ((a[i] == b[i]) & lt);
    end
    return lt;
  endfunction

  logic [TW-1:0]          pidx;
  logic [4:0]             sum;
  logic [NDIG-1:0][3:0]   fv;
  logic [NDIG-1:0][3:0]   dv_d;
  logic [TW-1:0]          t_d;
  dfh_ctl_t               ctl_d;

  dfh_ctl_t               ctl_q;
  logic [TW-1:0]          t_q;
  logic [NDIG-1:0][3:0]   dv_q, ds_q;

  // folded digits: low half gets pair sum, upper half clears, middle stays
  always_comb begin
    pidx = '0;
    sum  = '0;
    fv   = dv_i;
    for (int i = 0; i < NDIG; i++) begin
      if (2 * i < int'(t_i)) begin
        pidx  = t_i - TW'(i);
        sum   = {1'b0, dv_i[i]} + {1'b0, dv_i[pidx]};
        fv[i] = (sum >= RADIX) ? 4'(sum - RADIX) : sum[3:0];
      end else if (2 * i > int'(t_i) && i <= int'(t_i)) begin
        fv[i] = 4'd0;
      end
    end
  end

  // finished beats pass untouched
  always_comb begin
    ctl_d = ctl_i;
    if (ctl_i.done) begin
      dv_d = dv_i;
      t_d  = t_i;
    end else begin
      dv_d       = fv;
      t_d        = t_i >> 1;
      ctl_d.done = dig_lt(fv, ds_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q  <= t_d;
      dv_q <= dv_d;
      ds_q <= ds_i;
    end
  end

  assign ctl_o = ctl_q;
  assign t_o   = t_q;
  assign dv_o  = dv_q;
  assign ds_o  = ds_q;

endmodule
`default_nettype wire

@@ rtl/dfh_pack.sv @@
`default_nettype none
// Rebuilds the index one digit per stage, most significant first.
module dfh_pack import dfh_pkg::*; #(
  parameter int NDIG = 10,
  parameter int POS  = 9
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire dfh_ctl_t               ctl_i,
  input  wire logic [SIZE_W-1:0]      acc_i,
  input  wire logic [NDIG-1:0][3:0]   dv_i,
  output dfh_ctl_t                    ctl_o,
  output logic [SIZE_W-1:0]           acc_o,
  output logic [NDIG-1:0][3:0]        dv_o
);

  logic [SIZE_W-1:0]      acc_d;

  dfh_ctl_t               ctl_q;
  logic [SIZE_W-1:0]      acc_q;
  logic [NDIG-1:0][3:0]   dv_q;

  // acc * 10 + digit, kept mod 2^31
  assign acc_d = (acc_i << 3) + (acc_i << 1) + SIZE_W'(dv_i[POS]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= acc_d;
      dv_q  <= dv_i;
    end
  end

  assign ctl_o = ctl_q;
  assign acc_o = acc_q;
  assign dv_o  = dv_q;

endmodule
`default_nettype wire

@@ rtl/digit_folding_hash_index.sv @@
`default_nettype none
// Channel   Dir  Payload            Beat
// key_i     in   key (32, signed)   valid & ready
// index_o   out  index (31)         valid & ready
// cfg_i     in   table_size (31)    valid & ready, ready held high
//
// Split, top-digit pick, fold and rebuild stages are all pipelined, so
// throughput is one key per cycle while index_o does not stall.
// Reset clears the stage valid bits and sets table_size to 1024.
// A stall on index_o holds only the full stages behind it; bubbles still
// move up, so no beat is lost or repeated.
module digit_folding_hash_index import dfh_pkg::*; #(
  parameter int DIGITS = 10
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dfh_key_if.sink    key_i,
  dfh_index_if.source index_o,
  dfh_cfg_if.sink    cfg_i
);

  localparam int NDIG   = (DIGITS > 10) ? DIGITS : 10;
  localparam int ROUNDS = $clog2(DIGITS);
  localparam int TW     = $clog2(NDIG);
  localparam int NS     = 2 * NDIG + ROUNDS + 1;

  // table size register, clamped on write
  logic [SIZE_W-1:0] size_q;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= RESET_SIZE;
    end else if (cfg_i.valid) begin
      size_q <= (cfg_i.table_size < MIN_TABLE) ? MIN_TABLE : cfg_i.table_size;
    end
  end

  // key magnitude and early exit
  logic [KEY_W-1:0] key_u, mag;
  dfh_ctl_t         in_ctl;
  assign key_u        = KEY_W'(key_i.key);
  assign mag          = key_u[KEY_W-1] ? (32'd0 - key_u) : key_u;
  assign in_ctl.valid = key_i.valid;
  assign in_ctl.done  = mag < {1'b0, size_q};

  // stage enables: a stage loads when empty or when the next one loads
  logic [NS-1:0] v;
  logic [NS:0]   en;
  assign en[NS] = index_o.ready;
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = ~v[k] | en[k+1];
  end
  assign key_i.ready = en[0];

  // digit split
  dfh_ctl_t             sp_ctl [NDIG+1];
  logic [KEY_W-1:0]     sp_xk  [NDIG+1];
  logic [SIZE_W-1:0]    sp_xs  [NDIG+1];
  logic [NDIG-1:0][3:0] sp_dk  [NDIG+1];
  logic [NDIG-1:0][3:0] sp_ds  [NDIG+1];

  assign sp_ctl[0] = in_ctl;
  assign sp_xk[0]  = mag;
  assign sp_xs[0]  = size_q;
  assign sp_dk[0]  = '0;
  assign sp_ds[0]  = '0;

  for (genvar k = 0; k < NDIG; k++) begin : g_split
    dfh_split #(.NDIG(NDIG), .POS(k)) u_split (
      .clk_i, .rst_ni, .en_i(en[k]),
      .ctl_i(sp_ctl[k]),   .xk_i(sp_xk[k]),   .xs_i(sp_xs[k]),
      .dk_i(sp_dk[k]),     .ds_i(sp_ds[k]),
      .ctl_o(sp_ctl[k+1]), .xk_o(sp_xk[k+1]), .xs_o(sp_xs[k+1]),
      .dk_o(sp_dk[k+1]),   .ds_o(sp_ds[k+1])
    );
    assign v[k] = sp_ctl[k+1].valid;
  end

  // top digit, then fold rounds
  dfh_ctl_t             fd_ctl [ROUNDS+1];
  logic [TW-1:0]        fd_t   [ROUNDS+1];
  logic [NDIG-1:0][3:0] fd_dv  [ROUNDS+1];
  logic [NDIG-1:0][3:0] fd_ds  [ROUNDS+1];

  dfh_lead #(.NDIG(NDIG), .DIGITS(DIGITS), .TW(TW)) u_lead (
    .clk_i, .rst_ni, .en_i(en[NDIG]),
    .ctl_i(sp_ctl[NDIG]), .dv_i(sp_dk[NDIG]), .ds_i(sp_ds[NDIG]),
    .ctl_o(fd_ctl[0]), .t_o(fd_t[0]), .dv_o(fd_dv[0]), .ds_o(fd_ds[0])
  );
  assign v[NDIG] = fd_ctl[0].valid;

  for (genvar r = 0; r < ROUNDS; r++) begin : g_fold
    dfh_fold #(.NDIG(NDIG), .TW(TW)) u_fold (
      .clk_i, .rst_ni, .en_i(en[NDIG+1+r]),
      .ctl_i(fd_ctl[r]),   .t_i(fd_t[r]),   .dv_i(fd_dv[r]),   .ds_i(fd_ds[r]),
      .ctl_o(fd_ctl[r+1]), .t_o(fd_t[r+1]), .dv_o(fd_dv[r+1]), .ds_o(fd_ds[r+1])
    );
    assign v[NDIG+1+r] = fd_ctl[r+1].valid;
  end

  // rebuild binary index
  localparam int PB = NDIG + 1 + ROUNDS;
  dfh_ctl_t             pk_ctl [NDIG+1];
  logic [SIZE_W-1:0]    pk_acc [NDIG+1];
  logic [NDIG-1:0][3:0] pk_dv  [NDIG+1];

  assign pk_ctl[0] = fd_ctl[ROUNDS];
  assign pk_acc[0] = '0;
  assign pk_dv[0]  = fd_dv[ROUNDS];

  for (genvar k = 0; k < NDIG; k++) begin : g_pack
    dfh_pack #(.NDIG(NDIG), .POS(NDIG - 1 - k)) u_pack (
      .clk_i, .rst_ni, .en_i(en[PB+k]),
      .ctl_i(pk_ctl[k]),   .acc_i(pk_acc[k]),   .dv_i(pk_dv[k]),
      .ctl_o(pk_ctl[k+1]), .acc_o(pk_acc[k+1]), .dv_o(pk_dv[k+1])
    );
    assign v[PB+k] = pk_ctl[k+1].valid;
  end

  assign index_o.valid = pk_ctl[NDIG].valid;
  assign index_o.index = pk_acc[NDIG];

  // input backs up only when every stage is full and the output is held
  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !key_i.ready |-> (index_o.valid && !index_o.ready))
    else $error("input stalled with room in the pipeline");

  // size register never drops under the minimum
  a_size_min : assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_q >= MIN_TABLE)
    else $error("table size below minimum");

  // every beat leaving the last fold round has reached a value below size
  a_fold_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fd_ctl[ROUNDS].valid |-> fd_ctl[ROUNDS].done)
    else $error("fold rounds exhausted before value fell below size");

endmodule
`default_nettype wire
